/* hw/rtl/wsfp_pkg.sv */
// Package with the codes, result record and opcode helpers of the frame parser.
package wsfp_pkg;

	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	localparam logic [6:0] SHORT_MAX_LEN = 7'd125;
	localparam logic [6:0] LEN16_CODE    = 7'd126;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] MASK_BYTES  = 4'd4;

	localparam logic [1:0] KIND_HDR = 2'd0;
	localparam logic [1:0] KIND_PAY = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_PROTO   = 2'd1;
	localparam logic [1:0] ERR_TOO_BIG = 2'd2;

	localparam logic [31:0] MAX_MSG_RESET = 32'd65536;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic        fend;
		logic [3:0]  opcode;
		logic        fin;
		logic        text;
		logic        cont;
		logic [15:0] close;
		logic [1:0]  err;
	} result_t;

	function automatic logic is_data_op(input logic [3:0] op);
		return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN);
	endfunction

	function automatic logic is_known_op(input logic [3:0] op);
		return is_data_op(op) || (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
	endfunction

endpackage

/* hw/rtl/websocket_frame_parser_core.sv */
// Top level of the byte-serial frame parser with its two-entry result queue.
// Each result is registered into the queue at the edge that accepts its byte.
// Throughput: one byte per cycle unless in_stall; the state update is one register stage.
// A two-entry result queue takes input bytes while the output stalls, until it is full.
// Reset: arst_n clears all parse state, the error latch and the queue; limit resets to 65536.
module websocket_frame_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_kind,
	output logic [7:0]  payload_byte,
	output logic        frame_end,
	output logic [3:0]  frame_opcode,
	output logic        frame_fin,
	output logic        message_is_text,
	output logic        waiting_continuation,
	output logic [15:0] close_status,
	output logic [1:0]  error_code
);
	import wsfp_pkg::*;

	localparam logic [2:0] PH_HDR0 = 3'd0;
	localparam logic [2:0] PH_HDR1 = 3'd1;
	localparam logic [2:0] PH_EXT  = 3'd2;
	localparam logic [2:0] PH_MASK = 3'd3;
	localparam logic [2:0] PH_PAY  = 3'd4;
	localparam logic [2:0] PH_ERR  = 3'd5;

	logic [31:0] max_q;
	logic [2:0]  phase_q, n_phase;
	logic [3:0]  op_q, n_op;
	logic        fin_q, n_fin;
	logic        mask_q, n_mask;
	logic [3:0]  fbc_q, n_fbc;
	logic [63:0] left_q, n_left;
	logic [31:0] key_q, n_key;
	logic [1:0]  idx_q, n_idx;
	logic [31:0] mlen_q, n_mlen;
	logic        text_q, n_text;
	logic        cont_q, n_cont;
	logic [15:0] close_q, n_close;
	logic [1:0]  err_q, n_err;
	logic [7:0]  stage_q, n_stage;

	logic        push, pop;
	logic [1:0]  cnt_q;
	result_t     ent0_q, ent1_q, res;

	logic        lk_go, fin_go, err_go, too_big;
	logic [1:0]  err_code;
	logic [63:0] lk_len;
	logic [7:0]  mbyte;
	logic [1:0]  kind;
	logic [7:0]  pb;
	logic        fend;

	assign cfg_ready = 1'b1;
	assign in_stall  = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	always_comb begin
		n_phase  = phase_q;
		n_op     = op_q;
		n_fin    = fin_q;
		n_mask   = mask_q;
		n_fbc    = fbc_q;
		n_left   = left_q;
		n_key    = key_q;
		n_idx    = idx_q;
		n_mlen   = mlen_q;
		n_text   = text_q;
		n_cont   = cont_q;
		n_close  = close_q;
		n_err    = err_q;
		n_stage  = stage_q;
		kind     = KIND_HDR;
		pb       = 8'd0;
		fend     = 1'b0;
		lk_go    = 1'b0;
		lk_len   = 64'd0;
		fin_go   = 1'b0;
		err_go   = 1'b0;
		err_code = ERR_NONE;
		too_big  = 1'b0;
		mbyte    = 8'd0;

		unique case (phase_q)
			PH_HDR0: begin
				n_fin   = rx_byte[7];
				n_op    = rx_byte[3:0];
				n_phase = PH_HDR1;
			end
			PH_HDR1: begin
				n_mask = rx_byte[7];
				n_key  = 32'd0;
				n_idx  = 2'd0;
				n_left = 64'd0;
				if (rx_byte[6:0] <= SHORT_MAX_LEN) begin
					lk_go  = 1'b1;
					lk_len = {57'd0, rx_byte[6:0]};
				end else if (!is_data_op(op_q)) begin
					err_go   = 1'b1;
					err_code = ERR_PROTO;
				end else begin
					n_fbc   = (rx_byte[6:0] == LEN16_CODE) ? EXT16_BYTES : EXT64_BYTES;
					n_phase = PH_EXT;
				end
			end
			PH_EXT: begin
				n_left = {left_q[55:0], rx_byte};
				n_fbc  = fbc_q - 4'd1;
				if (n_fbc == 4'd0) begin
					lk_go  = 1'b1;
					lk_len = n_left;
				end
			end
			PH_MASK: begin
				n_key = {key_q[23:0], rx_byte};
				n_fbc = fbc_q - 4'd1;
				if (n_fbc == 4'd0) begin
					if (left_q == 64'd0) begin
						fin_go = 1'b1;
					end else begin
						n_phase = PH_PAY;
					end
				end
			end
			PH_PAY: begin
				if (mask_q) begin
					unique case (idx_q)
						2'd0: mbyte = key_q[31:24];
						2'd1: mbyte = key_q[23:16];
						2'd2: mbyte = key_q[15:8];
						default: mbyte = key_q[7:0];
					endcase
				end
				pb    = rx_byte ^ mbyte;
				n_idx = idx_q + 2'd1;
				kind  = KIND_PAY;
				if (op_q == OP_CLOSE) begin
					if (fbc_q == 4'd0) begin
						n_stage = pb;
						n_fbc   = 4'd1;
					end else if (fbc_q == 4'd1) begin
						n_close = {stage_q, pb};
						n_fbc   = 4'd2;
					end
				end
				n_left = left_q - 64'd1;
				if (left_q == 64'd1) begin
					fin_go = 1'b1;
				end
			end
			default: begin
				kind = KIND_ERR;
			end
		endcase

		if (lk_go) begin
			// The limit check avoids overflow: the accumulated length never exceeds 32 bits.
			too_big = (|lk_len[63:32]) || (mlen_q > max_q) || (lk_len[31:0] > (max_q - mlen_q));
			priority if (too_big) begin
				err_go   = 1'b1;
				err_code = ERR_TOO_BIG;
			end else if (cont_q && ((op_q == OP_TEXT) || (op_q == OP_BIN))) begin
				err_go   = 1'b1;
				err_code = ERR_PROTO;
			end else if (!is_known_op(op_q)) begin
				err_go   = 1'b1;
				err_code = ERR_PROTO;
			end else begin
				if (is_data_op(op_q)) begin
					if (op_q == OP_TEXT) begin
						n_text = 1'b1;
					end else if (op_q == OP_BIN) begin
						n_text = 1'b0;
					end
					n_mlen = mlen_q + lk_len[31:0];
				end
				n_left = lk_len;
				n_fbc  = 4'd0;
				if (n_mask) begin
					n_fbc   = MASK_BYTES;
					n_phase = PH_MASK;
				end else if (lk_len == 64'd0) begin
					fin_go = 1'b1;
				end else begin
					n_phase = PH_PAY;
				end
			end
		end

		if (fin_go) begin
			fend    = 1'b1;
			n_phase = PH_HDR0;
			if (is_data_op(op_q)) begin
				n_cont = !fin_q;
				if (fin_q) begin
					n_mlen = 32'd0;
				end
			end
		end

		if (err_go) begin
			n_err   = err_code;
			n_phase = PH_ERR;
			kind    = KIND_ERR;
		end

		if (kind == KIND_ERR) begin
			pb   = 8'd0;
			fend = 1'b0;
		end

		res.kind   = kind;
		res.data   = pb;
		res.fend   = fend;
		res.opcode = n_op;
		res.fin    = n_fin;
		res.text   = n_text;
		res.cont   = n_cont;
		res.close  = n_close;
		res.err    = n_err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= MAX_MSG_RESET;
			phase_q <= PH_HDR0;
			op_q    <= 4'd0;
			fin_q   <= 1'b0;
			mask_q  <= 1'b0;
			fbc_q   <= 4'd0;
			left_q  <= 64'd0;
			key_q   <= 32'd0;
			idx_q   <= 2'd0;
			mlen_q  <= 32'd0;
			text_q  <= 1'b0;
			cont_q  <= 1'b0;
			close_q <= 16'd0;
			err_q   <= ERR_NONE;
			stage_q <= 8'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
			if (push) begin
				phase_q <= n_phase;
				op_q    <= n_op;
				fin_q   <= n_fin;
				mask_q  <= n_mask;
				fbc_q   <= n_fbc;
				left_q  <= n_left;
				key_q   <= n_key;
				idx_q   <= n_idx;
				mlen_q  <= n_mlen;
				text_q  <= n_text;
				cont_q  <= n_cont;
				close_q <= n_close;
				err_q   <= n_err;
				stage_q <= n_stage;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					ent0_q <= res;
				end else begin
					ent1_q <= res;
				end
			end
			2'b01: begin
				ent0_q <= ent1_q;
			end
			2'b11: begin
				ent0_q <= res;
			end
			default: begin
				ent0_q <= ent0_q;
			end
		endcase
	end

	assign out_kind             = ent0_q.kind;
	assign payload_byte         = ent0_q.data;
	assign frame_end            = ent0_q.fend;
	assign frame_opcode         = ent0_q.opcode;
	assign frame_fin            = ent0_q.fin;
	assign message_is_text      = ent0_q.text;
	assign waiting_continuation = ent0_q.cont;
	assign close_status         = ent0_q.close;
	assign error_code           = ent0_q.err;

`ifndef SYNTHESIS
	// The error phase and the error latch always agree.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERR) == (err_q != ERR_NONE))
		else $error("error phase and error latch disagree");

	// Once an error is latched it never changes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_NONE) |=> (err_q == $past(err_q)))
		else $error("latched error changed");

	// An error result always carries an error code and no payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_kind == KIND_ERR)) |->
		((error_code != ERR_NONE) && (payload_byte == 8'd0) && !frame_end))
		else $error("error result is malformed");

	// A full queue always presents a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with an empty result queue");
`endif

endmodule

/* verif/frame_parse_checker.sv */
// Checker that predicts every frame parser result and compares it with the block's output.
`timescale 1ns / 100ps

module frame_parse_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  out_kind,
	input  logic [7:0]  payload_byte,
	input  logic        frame_end,
	input  logic [3:0]  frame_opcode,
	input  logic        frame_fin,
	input  logic        message_is_text,
	input  logic        waiting_continuation,
	input  logic [15:0] close_status,
	input  logic [1:0]  error_code,
	input  logic        end_of_test,
	output int unsigned mismatch_count,
	output int unsigned outstanding,
	output int unsigned results_checked
);
	import wsfp_pkg::*;

	typedef enum logic [2:0] {
		AT_HDR0,
		AT_HDR1,
		AT_EXTLEN,
		AT_MASK,
		AT_PAYLOAD,
		AT_ERROR
	} parse_stage_t;

	parse_stage_t stage;
	logic [31:0] size_limit;
	logic [3:0]  opcode;
	logic        fin;
	logic        masked;
	logic [3:0]  field_cnt;
	logic [63:0] remaining;
	logic [31:0] key;
	logic [1:0]  key_pos;
	logic [63:0] msg_len;
	logic        text;
	logic        cont;
	logic [15:0] close_val;
	logic [7:0]  close_hi;
	logic [1:0]  fault;

	result_t expected_results[$];
	bit      leftovers_checked = 1'b0;

	initial begin
		mismatch_count = 0;
		outstanding = 0;
		results_checked = 0;
	end

	function automatic logic carries_data(input logic [3:0] op);
		return op <= OP_BIN;
	endfunction

	function automatic logic known_opcode(input logic [3:0] op);
		return (op <= OP_BIN) || (op >= OP_CLOSE && op <= OP_PONG);
	endfunction

	function automatic void latch_fault(input logic [1:0] code, inout result_t r);
		fault = code;
		stage = AT_ERROR;
		r.kind = KIND_ERR;
	endfunction

	function automatic void end_frame(inout result_t r);
		r.fend = 1'b1;
		stage = AT_HDR0;
		if (carries_data(opcode)) begin
			cont = !fin;
			if (fin)
				msg_len = '0;
		end
	endfunction

	function automatic void accept_length(input logic [63:0] len, inout result_t r);
		if ({1'b0, msg_len} + {1'b0, len} > {33'b0, size_limit}) begin
			latch_fault(ERR_TOO_BIG, r);
		end else if (cont && (opcode == OP_TEXT || opcode == OP_BIN)) begin
			latch_fault(ERR_PROTO, r);
		end else if (!known_opcode(opcode)) begin
			latch_fault(ERR_PROTO, r);
		end else begin
			if (carries_data(opcode)) begin
				if (opcode == OP_TEXT)
					text = 1'b1;
				else if (opcode == OP_BIN)
					text = 1'b0;
				msg_len += len;
			end
			remaining = len;
			field_cnt = '0;
			if (masked) begin
				field_cnt = MASK_BYTES;
				stage = AT_MASK;
			end else if (len == 0) begin
				end_frame(r);
			end else begin
				stage = AT_PAYLOAD;
			end
		end
	endfunction

	function automatic result_t parse_byte(input logic [7:0] b);
		result_t r;
		logic [7:0] m;
		logic [7:0] pb;
		r = '0;
		r.kind = KIND_HDR;
		case (stage)
			AT_HDR0: begin
				fin = b[7];
				opcode = b[3:0];
				stage = AT_HDR1;
			end
			AT_HDR1: begin
				masked = b[7];
				key = '0;
				key_pos = '0;
				remaining = '0;
				if (b[6:0] <= SHORT_MAX_LEN) begin
					accept_length(64'(b[6:0]), r);
				end else if (!carries_data(opcode)) begin
					latch_fault(ERR_PROTO, r);
				end else begin
					field_cnt = (b[6:0] == LEN16_CODE) ? EXT16_BYTES : EXT64_BYTES;
					stage = AT_EXTLEN;
				end
			end
			AT_EXTLEN: begin
				remaining = {remaining[55:0], b};
				field_cnt = field_cnt - 4'd1;
				if (field_cnt == 0)
					accept_length(remaining, r);
			end
			AT_MASK: begin
				key = {key[23:0], b};
				field_cnt = field_cnt - 4'd1;
				if (field_cnt == 0) begin
					if (remaining == 0)
						end_frame(r);
					else
						stage = AT_PAYLOAD;
				end
			end
			AT_PAYLOAD: begin
				m = masked ? key[8 * (3 - key_pos) +: 8] : 8'h00;
				pb = b ^ m;
				key_pos = key_pos + 2'd1;
				r.kind = KIND_PAY;
				r.data = pb;
				if (opcode == OP_CLOSE) begin
					if (field_cnt == 0) begin
						close_hi = pb;
						field_cnt = 4'd1;
					end else if (field_cnt == 1) begin
						close_val = {close_hi, pb};
						field_cnt = 4'd2;
					end
				end
				remaining = remaining - 64'd1;
				if (remaining == 0)
					end_frame(r);
			end
			default: begin
				r.kind = KIND_ERR;
			end
		endcase
		if (r.kind == KIND_ERR) begin
			r.data = '0;
			r.fend = 1'b0;
		end
		r.opcode = opcode;
		r.fin = fin;
		r.text = text;
		r.cont = cont;
		r.close = close_val;
		r.err = fault;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s is %0h, expected %0h",
				results_checked, name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			stage = AT_HDR0;
			size_limit = MAX_MSG_RESET;
			opcode = '0;
			fin = 1'b0;
			masked = 1'b0;
			field_cnt = '0;
			remaining = '0;
			key = '0;
			key_pos = '0;
			msg_len = '0;
			text = 1'b0;
			cont = 1'b0;
			close_val = '0;
			close_hi = '0;
			fault = ERR_NONE;
			expected_results.delete();
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result, kind %0d byte %0h",
						out_kind, payload_byte));
				end else begin
					want = expected_results.pop_front();
					check_field("out_kind", 16'(out_kind), 16'(want.kind));
					check_field("payload_byte", 16'(payload_byte), 16'(want.data));
					check_field("frame_end", 16'(frame_end), 16'(want.fend));
					check_field("frame_opcode", 16'(frame_opcode), 16'(want.opcode));
					check_field("frame_fin", 16'(frame_fin), 16'(want.fin));
					check_field("message_is_text", 16'(message_is_text), 16'(want.text));
					check_field("waiting_continuation", 16'(waiting_continuation),
						16'(want.cont));
					check_field("close_status", close_status, want.close);
					check_field("error_code", 16'(error_code), 16'(want.err));
					results_checked++;
				end
			end
			if (cfg_valid && cfg_ready)
				size_limit = cfg_data;
			if (in_valid && !in_stall)
				expected_results.push_back(parse_byte(rx_byte));
			if (end_of_test && !leftovers_checked) begin
				leftovers_checked = 1'b1;
				if (expected_results.size() != 0)
					report_mismatch($sformatf("%0d expected results never arrived",
						expected_results.size()));
			end
			outstanding = expected_results.size();
		end
	end

endmodule

/* verif/websocket_frame_parser_core_test.sv */
// Testbench top that feeds frame streams and limit writes to the parser and gives the verdict.
`timescale 1ns / 100ps

module websocket_frame_parser_core_test;
	import wsfp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam logic [6:0] LEN64_CODE = 7'd127;

	typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;
	typedef enum int {
		TAIL_CTRL_EXTLEN,
		TAIL_DATA_MID_MSG,
		TAIL_UNKNOWN_OP,
		TAIL_TOO_BIG
	} tail_case_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  out_kind;
	logic [7:0]  payload_byte;
	logic        frame_end;
	logic [3:0]  frame_opcode;
	logic        frame_fin;
	logic        message_is_text;
	logic        waiting_continuation;
	logic [15:0] close_status;
	logic [1:0]  error_code;
	logic        end_of_test = 1'b0;

	int unsigned mismatch_count;
	int unsigned outstanding;
	int unsigned results_checked;

	int unsigned cycles = 0;
	int unsigned bytes_sent = 0;
	int unsigned frames_sent = 0;
	int          stall_left = 0;
	bit          calm = 1'b0;
	logic [31:0] gen_limit = MAX_MSG_RESET;
	logic [63:0] gen_msg_len = '0;
	bit          gen_in_msg = 1'b0;
	logic [31:0] mid_limit;
	tail_case_t  tail_case;

	websocket_frame_parser_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_kind(out_kind),
		.payload_byte(payload_byte),
		.frame_end(frame_end),
		.frame_opcode(frame_opcode),
		.frame_fin(frame_fin),
		.message_is_text(message_is_text),
		.waiting_continuation(waiting_continuation),
		.close_status(close_status),
		.error_code(error_code)
	);

	frame_parse_checker parse_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_kind(out_kind),
		.payload_byte(payload_byte),
		.frame_end(frame_end),
		.frame_opcode(frame_opcode),
		.frame_fin(frame_fin),
		.message_is_text(message_is_text),
		.waiting_continuation(waiting_continuation),
		.close_status(close_status),
		.error_code(error_code),
		.end_of_test(end_of_test),
		.mismatch_count(mismatch_count),
		.outstanding(outstanding),
		.results_checked(results_checked)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	initial begin
		forever begin
			@(negedge clk);
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
			else if (!calm && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [3:0] op, input logic fin, input int unsigned len,
			input len_form_t form, input logic masked, input int fill);
		logic [31:0] mkey;
		logic [63:0] len64;
		len64 = 64'(len);
		mkey = $urandom;
		send_byte({fin, 3'($urandom), op});
		if (form == LEN_SHORT) begin
			send_byte({masked, 7'(len)});
		end else if (form == LEN_EXT16) begin
			send_byte({masked, LEN16_CODE});
			send_byte(len64[15:8]);
			send_byte(len64[7:0]);
		end else begin
			send_byte({masked, LEN64_CODE});
			for (int i = 7; i >= 0; i--)
				send_byte(len64[8 * i +: 8]);
		end
		if (masked)
			for (int i = 3; i >= 0; i--)
				send_byte(mkey[8 * i +: 8]);
		for (int unsigned i = 0; i < len; i++)
			send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
		if (op <= OP_BIN) begin
			gen_msg_len += len64;
			gen_in_msg = !fin;
			if (fin)
				gen_msg_len = '0;
		end
		frames_sent++;
	endtask

	task automatic send_random_frame(input bit empty_only);
		logic [3:0]  op;
		logic        fin;
		int unsigned len;
		len_form_t   form;
		int          r;
		logic [63:0] room;
		room = {32'b0, gen_limit} - gen_msg_len;
		r = $urandom_range(0, 99);
		form = LEN_SHORT;
		if (r < 25) begin
			case ($urandom_range(0, 2))
				0: op = OP_CLOSE;
				1: op = OP_PING;
				default: op = OP_PONG;
			endcase
			fin = ($urandom_range(0, 7) != 0);
			len = (op == OP_CLOSE) ? $urandom_range(0, 4) : $urandom_range(0, 8);
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(0, 125);
		end else begin
			if (gen_in_msg || r < 30)
				op = OP_CONT;
			else
				op = (r < 65) ? OP_TEXT : OP_BIN;
			fin = 1'($urandom_range(0, 1));
			r = $urandom_range(0, 99);
			if (r < 70)
				len = $urandom_range(0, 12);
			else if (r < 95)
				len = $urandom_range(13, 125);
			else
				len = $urandom_range(126, 300);
			if (len > 125)
				form = LEN_EXT16;
			else if ($urandom_range(0, 9) == 0)
				form = ($urandom_range(0, 1) != 0) ? LEN_EXT16 : LEN_EXT64;
		end
		if (empty_only || len > room)
			len = empty_only ? 0 : 32'(room);
		if ($urandom_range(0, 19) == 0)
			calm = !calm;
		send_frame(op, fin, len, form, 1'($urandom_range(0, 1)), -1);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic end_message();
		if (gen_in_msg)
			send_frame(OP_CONT, 1'b1, 0, LEN_SHORT, 1'b0, -1);
	endtask

	task automatic write_limit(input logic [31:0] value);
		end_message();
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		gen_limit = value;
	endtask

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_frame(OP_PING, 1'b1, 0, LEN_SHORT, 1'b0, -1);
		send_frame(OP_BIN, 1'b1, 0, LEN_SHORT, 1'b1, -1);
		send_frame(OP_CLOSE, 1'b1, 3, LEN_SHORT, 1'b0, 8'hFF);
		send_frame(OP_TEXT, 1'b0, 1, LEN_EXT16, 1'b0, 8'h00);
		send_frame(OP_CONT, 1'b1, 1, LEN_SHORT, 1'b1, 8'hA5);
		send_frame(OP_PONG, 1'b1, 0, LEN_SHORT, 1'b0, -1);

		while (bytes_sent < 600)
			send_random_frame(1'b0);

		write_limit(32'h0000_0000);
		while (bytes_sent < 640)
			send_random_frame(1'b1);

		write_limit(32'hFFFF_FFFF);
		while (bytes_sent < 1040)
			send_random_frame(1'b0);

		mid_limit = $urandom_range(20, 300);
		write_limit(mid_limit);
		while (bytes_sent < 1620)
			send_random_frame(1'b0);

		end_message();
		calm = 1'b0;
		tail_case = tail_case_t'($urandom_range(0, 3));
		case (tail_case)
			TAIL_CTRL_EXTLEN: begin
				send_byte({1'b1, 3'b000, OP_PING});
				send_byte({1'b0, LEN16_CODE});
			end
			TAIL_DATA_MID_MSG: begin
				send_frame(OP_TEXT, 1'b0, 1, LEN_SHORT, 1'b0, -1);
				send_byte({1'b1, 3'b000, OP_BIN});
				send_byte(8'd0);
			end
			TAIL_UNKNOWN_OP: begin
				send_byte({1'b1, 3'b000, ($urandom_range(0, 1) != 0) ?
					4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15))});
				send_byte(8'd1);
			end
			default: begin
				send_byte({1'b1, 3'b000, OP_BIN});
				send_byte({1'b0, LEN64_CODE});
				send_byte(8'($urandom_range(1, 255)));
				repeat (7) send_byte(8'($urandom));
			end
		endcase
		repeat (15) send_byte(8'($urandom));

		wait_idle();
		repeat (4) @(negedge clk);
		end_of_test <= 1'b1;
		repeat (3) @(negedge clk);

		$display("Sent %0d bytes in %0d frames under limits 65536, 0, 4294967295 and %0d.",
			bytes_sent, frames_sent, mid_limit);
		$display("Checked %0d results; the stream ended with the %s error case.",
			results_checked, tail_case.name());
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
